/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the biquad RTL.
// Each macro checks one implication on the rising clock edge and is
// disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BQD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("biquad assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("biquad assertion failed");

`endif

/* hw/rtl/bqd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Biquad filter package
// Shared constants, register indexes and the control structs passed between
// the sequencer and the bit-serial multiply-accumulate unit.
// ---------------------------------------------------------------------------
package bqd_pkg;

  // Default widths of the sample and of the coefficient fraction.
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // Minimum width of a delay element (signed, fraction included).
  localparam int DELAY_BITS = 40;

  // Register port widths.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register indexes (word addresses on the register port).
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_B0     = 2'd1,
    REG_A1     = 2'd2,
    REG_A2     = 2'd3
  } reg_idx_e;

  // Command to the multiply-accumulate unit.
  typedef struct packed {
    logic start;     // load operands and begin a product
    logic load_acc;  // preset the accumulator with the init value
    logic negate;    // subtract the product instead of adding it
    logic is_signed; // multiplier is two's complement
  } mac_cmd_t;

  // Status of the multiply-accumulate unit.
  typedef struct packed {
    logic busy;  // stepping through multiplier bits
    logic done;  // one-cycle pulse: accumulator holds the final sum
  } mac_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/bqd_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Biquad configuration registers
// APB-style register file holding the enable bit, unsigned Q1.F b0 and Q2.F
// a1 and a2. Writes complete in the access phase; pready is always high.
// ---------------------------------------------------------------------------
module bqd_regs #(
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel_i,
  input  wire logic                            penable_i,
  input  wire logic                            pwrite_i,
  input  wire logic [bqd_pkg::APB_ADDR_W-1:0]  paddr_i,
  input  wire logic [bqd_pkg::APB_DATA_W-1:0]  pwdata_i,
  output logic      [bqd_pkg::APB_DATA_W-1:0]  prdata_o,
  output logic                                 pready_o,
  output logic                                 enable_o,
  output logic      [COEF_FRAC_BITS:0]         coef_b0_o,
  output logic      [COEF_FRAC_BITS+1:0]       coef_a1_o,
  output logic      [COEF_FRAC_BITS+1:0]       coef_a2_o
);
  import bqd_pkg::*;

  localparam int B0_W = COEF_FRAC_BITS + 1;
  localparam int A_W  = COEF_FRAC_BITS + 2;

  logic             enable_q;
  logic [B0_W-1:0]  coef_b0_q;
  logic [A_W-1:0]   coef_a1_q;
  logic [A_W-1:0]   coef_a2_q;
  logic             wr_en;
  reg_idx_e         reg_idx;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_idx = reg_idx_e'(paddr_i[APB_ADDR_W-1:2]);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      coef_b0_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE: enable_q  <= pwdata_i[0];
        REG_B0:     coef_b0_q <= pwdata_i[B0_W-1:0];
        REG_A1:     coef_a1_q <= pwdata_i[A_W-1:0];
        REG_A2:     coef_a2_q <= pwdata_i[A_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; signed coefficients read back sign-extended.
  always_comb begin
    case (reg_idx)
      REG_ENABLE: prdata_o = {{(APB_DATA_W-1){1'b0}}, enable_q};
      REG_B0:     prdata_o = {{(APB_DATA_W-B0_W){1'b0}}, coef_b0_q};
      REG_A1:     prdata_o = {{(APB_DATA_W-A_W){coef_a1_q[A_W-1]}}, coef_a1_q};
      REG_A2:     prdata_o = {{(APB_DATA_W-A_W){coef_a2_q[A_W-1]}}, coef_a2_q};
      default:    prdata_o = '0;
    endcase
  end

  assign pready_o  = 1'b1;
  assign enable_o  = enable_q;
  assign coef_b0_o = coef_b0_q;
  assign coef_a1_o = coef_a1_q;
  assign coef_a2_o = coef_a2_q;

endmodule
`default_nettype wire

/* hw/rtl/bqd_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Bit-serial multiply-accumulate unit
// Shifts the multiplier out one bit per cycle, LSB first, and adds or
// subtracts the left-shifting multiplicand into a wide accumulator.
// ---------------------------------------------------------------------------
module bqd_mac #(
  parameter int ACC_W   = 60,
  parameter int MCAND_W = 42,
  parameter int MULT_W  = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bqd_pkg::mac_cmd_t cmd_i,
  input  wire logic [ACC_W-1:0]  acc_init_i,
  input  wire logic [MCAND_W-1:0] mcand_i,
  input  wire logic [MULT_W-1:0] mult_i,
  output bqd_pkg::mac_sts_t      sts_o,
  output logic      [ACC_W-1:0]  acc_o
);
  import bqd_pkg::*;

  localparam int CNT_W = $clog2(MULT_W + 1);

  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  mcand_q;
  logic [MULT_W-1:0] mult_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              negate_q;
  logic              signed_q;

  logic              last;
  logic              sub;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  acc_d;

  // One partial product per cycle. The top bit of a signed multiplier
  // carries negative weight, which flips add and subtract.
  always_comb begin
    last   = (cnt_q == CNT_W'(1));
    sub    = mult_q[0] & (negate_q ^ (signed_q & last));
    addend = mult_q[0] ? (sub ? ~mcand_q : mcand_q) : '0;
    acc_d  = acc_q + addend + {{(ACC_W-1){1'b0}}, sub};
  end

  // Operand load and stepping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      negate_q <= 1'b0;
      signed_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        mcand_q  <= {{(ACC_W-MCAND_W){mcand_i[MCAND_W-1]}}, mcand_i};
        mult_q   <= mult_i;
        cnt_q    <= CNT_W'(MULT_W);
        busy_q   <= 1'b1;
        negate_q <= cmd_i.negate;
        signed_q <= cmd_i.is_signed;
        if (cmd_i.load_acc) begin
          acc_q <= acc_init_i;
        end
      end else if (busy_q) begin
        acc_q   <= acc_d;
        mcand_q <= {mcand_q[ACC_W-2:0], 1'b0};
        mult_q  <= {1'b0, mult_q[MULT_W-1:1]};
        cnt_q   <= cnt_q - CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;

  // A new product is only started once the previous one has finished.
  `BQD_ASSERT_NOW(a_start_when_idle, clk_i, rst_ni, cmd_i.start, !busy_q)
  // The bit counter never runs out while the unit is busy.
  `BQD_ASSERT_NOW(a_busy_has_bits, clk_i, rst_ni, busy_q, cnt_q != '0)
  // The final step is followed by exactly the done pulse.
  `BQD_ASSERT_NEXT(a_done_after_last, clk_i, rst_ni, busy_q && last, done_q && !busy_q)

endmodule
`default_nettype wire

/* hw/rtl/second_order_lowpass_biquad_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Second-order low-pass biquad unit
// Two-pole low-pass filter in direct form II with Q2.F feedback coefficients,
// a Q1.F b0, a bit-serial shared multiplier and an APB register port.
// ---------------------------------------------------------------------------
// With the filter enabled, each sample item goes through three products on
// one bit-serial multiplier that retires one coefficient bit per cycle:
// a1*w1, a2*w2 and b0*(w0+2w1+w2). The next item is accepted only once the
// result has been handed to the output register; with the filter disabled
// the sample is passed through unchanged. A new item is accepted while the
// previous result still waits in the output register. b1 = 2*b0 and b2 = b0
// are implied. A new delay value that does not fit its register is replaced
// by the sample scaled to Q.F; the output is rounded half up and saturated to
// SAMPLE_BITS. Registers: enable at 0x0, b0 at 0x4, a1 at 0x8, a2 at 0xC;
// write them only while the unit is idle.
// ---------------------------------------------------------------------------
module second_order_lowpass_biquad_unit #(
  parameter int SAMPLE_BITS    = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Sample items in.
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
  // Filtered items out.
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // [SAMPLE_BITS-1:0] filtered
  // Register port.
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [bqd_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [bqd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic      [bqd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                      pready
);
  import bqd_pkg::*;

  localparam int F       = COEF_FRAC_BITS;
  localparam int S       = SAMPLE_BITS;
  localparam int TDATA_W = ((S + 7) / 8) * 8;
  localparam int B0_W    = F + 1;
  localparam int A_W     = F + 2;
  localparam int DELAY_W = (S + F + 1 > DELAY_BITS) ? S + F + 1 : DELAY_BITS;
  localparam int SUM_W   = DELAY_W + 2;
  localparam int ACC_W   = (DELAY_W + F + 4 > S + 2 * F + 2) ?
                           DELAY_W + F + 4 : S + 2 * F + 2;
  localparam int Q1_W    = ACC_W - F;
  localparam int Q2_W    = ACC_W - 2 * F;

  localparam logic [ACC_W-1:0] HALF1 = {{(ACC_W-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [ACC_W-1:0] HALF2 = {{(ACC_W-1){1'b0}}, 1'b1} << (2 * F - 1);
  localparam logic [S-1:0]     SMAX  = {1'b0, {(S-1){1'b1}}};
  localparam logic [S-1:0]     SMIN  = {1'b1, {(S-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ROUND1,
    ST_SUM,
    ST_MUL3,
    ST_ROUND2,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [S-1:0]       sample_q;
  logic [DELAY_W-1:0] w0_q;
  logic [DELAY_W-1:0] w1_q;
  logic [DELAY_W-1:0] w2_q;
  logic [S-1:0]       res_q;
  logic               out_valid_q;
  logic [S-1:0]       out_data_q;

  logic               cfg_enable;
  logic [B0_W-1:0]    cfg_b0;
  logic [A_W-1:0]     cfg_a1;
  logic [A_W-1:0]     cfg_a2;

  mac_cmd_t           mac_cmd;
  mac_sts_t           mac_sts;
  logic [ACC_W-1:0]   mac_acc_init;
  logic [SUM_W-1:0]   mac_mcand;
  logic [A_W-1:0]     mac_mult;
  logic [ACC_W-1:0]   mac_acc;

  logic               in_acc;
  logic [S-1:0]       x_in;
  logic [Q2_W-1:0]    x_top;
  logic [SUM_W-1:0]   w0_ext;
  logic [SUM_W-1:0]   w1_ext;
  logic [SUM_W-1:0]   w2_ext;
  logic [SUM_W-1:0]   tap_sum;
  logic [ACC_W-1:0]   rnd1;
  logic [Q1_W-1:0]    q1;
  logic               fits1;
  logic [DELAY_W-1:0] x_scaled;
  logic [DELAY_W-1:0] w0_d;
  logic [ACC_W-1:0]   rnd2;
  logic [Q2_W-1:0]    q2;
  logic               fits2;
  logic [S-1:0]       y_d;
  logic               in_mul;

  // Register file.
  bqd_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .enable_o  (cfg_enable),
    .coef_b0_o (cfg_b0),
    .coef_a1_o (cfg_a1),
    .coef_a2_o (cfg_a2)
  );

  // Shared bit-serial multiplier.
  bqd_mac #(
    .ACC_W   (ACC_W),
    .MCAND_W (SUM_W),
    .MULT_W  (A_W)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (mac_cmd),
    .acc_init_i (mac_acc_init),
    .mcand_i    (mac_mcand),
    .mult_i     (mac_mult),
    .sts_o      (mac_sts),
    .acc_o      (mac_acc)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign x_in          = s_axis_tdata[S-1:0];
  assign x_top         = {{(Q2_W-S){x_in[S-1]}}, x_in};

  // Delay taps sign-extended to the tap-sum width.
  assign w0_ext  = {{2{w0_q[DELAY_W-1]}}, w0_q};
  assign w1_ext  = {{2{w1_q[DELAY_W-1]}}, w1_q};
  assign w2_ext  = {{2{w2_q[DELAY_W-1]}}, w2_q};
  assign tap_sum = w0_ext + {w1_ext[SUM_W-2:0], 1'b0} + w2_ext;

  // New delay value: round to Q.F, fall back to the scaled sample if it
  // does not fit the delay register.
  always_comb begin
    rnd1     = mac_acc + HALF1;
    q1       = rnd1[ACC_W-1:F];
    fits1    = (&q1[Q1_W-1:DELAY_W-1]) | ~(|q1[Q1_W-1:DELAY_W-1]);
    x_scaled = {{(DELAY_W-S-F){sample_q[S-1]}}, sample_q, {F{1'b0}}};
    w0_d     = fits1 ? q1[DELAY_W-1:0] : x_scaled;
  end

  // Output: round to an integer and saturate.
  always_comb begin
    rnd2  = mac_acc + HALF2;
    q2    = rnd2[ACC_W-1:2*F];
    fits2 = (&q2[Q2_W-1:S-1]) | ~(|q2[Q2_W-1:S-1]);
    y_d   = fits2 ? q2[S-1:0] : (q2[Q2_W-1] ? SMIN : SMAX);
  end

  // Multiplier commands: -a1*w1 on top of x<<2F, then -a2*w2, then b0*taps.
  always_comb begin
    mac_cmd      = '0;
    mac_acc_init = '0;
    mac_mcand    = '0;
    mac_mult     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && cfg_enable) begin
          mac_cmd.start     = 1'b1;
          mac_cmd.load_acc  = 1'b1;
          mac_cmd.negate    = 1'b1;
          mac_cmd.is_signed = 1'b1;
          mac_acc_init      = {x_top, {(2*F){1'b0}}};
          mac_mcand         = w1_ext;
          mac_mult          = cfg_a1;
        end
      end
      ST_MUL1: begin
        if (mac_sts.done) begin
          mac_cmd.start     = 1'b1;
          mac_cmd.negate    = 1'b1;
          mac_cmd.is_signed = 1'b1;
          mac_mcand         = w2_ext;
          mac_mult          = cfg_a2;
        end
      end
      ST_SUM: begin
        mac_cmd.start    = 1'b1;
        mac_cmd.load_acc = 1'b1;
        mac_mcand        = tap_sum;
        mac_mult         = {1'b0, cfg_b0};
      end
      default: ;
    endcase
  end

  // Sequencer, delay line and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w1_q        <= '0;
      w2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In the output state the handover below decides the valid flag.
      if (out_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sample_q <= x_in;
            if (cfg_enable) begin
              state_q <= ST_MUL1;
            end else begin
              res_q   <= x_in;
              state_q <= ST_OUT;
            end
          end
        end
        ST_MUL1: begin
          if (mac_sts.done) begin
            state_q <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (mac_sts.done) begin
            state_q <= ST_ROUND1;
          end
        end
        ST_ROUND1: begin
          w0_q    <= w0_d;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          state_q <= ST_MUL3;
        end
        ST_MUL3: begin
          if (mac_sts.done) begin
            state_q <= ST_ROUND2;
          end
        end
        ST_ROUND2: begin
          res_q   <= y_d;
          w2_q    <= w1_q;
          w1_q    <= w0_q;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TDATA_W-S){1'b0}}, out_data_q};

  assign in_mul = (state_q == ST_MUL1) || (state_q == ST_MUL2) || (state_q == ST_MUL3);

  // The multiplier only reports completion while a product is expected.
  `BQD_ASSERT_NOW(a_done_in_mul, clk_i, rst_ni, mac_sts.done, in_mul)
  // The multiplier is quiet whenever the sequencer is not using it.
  `BQD_ASSERT_NOW(a_mac_quiet, clk_i, rst_ni, state_q == ST_IDLE || state_q == ST_OUT, !mac_sts.busy)
  // A bypassed item goes straight to the output stage.
  `BQD_ASSERT_NEXT(a_bypass, clk_i, rst_ni, in_acc && !cfg_enable, state_q == ST_OUT)

endmodule
`default_nettype wire
